@@ design/sibg_pkg.sv @@
// ----------------------------------------------------------------------------
// sibg_pkg: shared types and constants of the static IMU initializer
// Window geometry, arithmetic widths, status codes, sequencer states and the
// structs that pass between the front queue, the back end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sibg_pkg;

   localparam int WIN_DEPTH   = 256;
   localparam int WIN_AW      = $clog2(WIN_DEPTH);
   localparam int FILL_W      = WIN_AW + 1;
   localparam int MIN_SAMPLES = 10;
   localparam int LANES       = 6;
   localparam int LAT_N       = 9;
   localparam int SUM_W       = 32 + WIN_AW;
   localparam int NUM_W       = SUM_W + 2;
   localparam int ACC_W       = 49 + WIN_AW;
   localparam int DIV_NW      = 64;
   localparam int DIV_DW      = 32;
   localparam int DIV_CW      = $clog2(DIV_NW);
   localparam int QUE_DEPTH   = 2;
   localparam int QUE_AW      = $clog2(QUE_DEPTH);
   localparam int CSR_IW      = 3;
   localparam int CSR_DW      = 31;

   localparam logic [CSR_IW-1:0] CSR_SETTLE    = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_WIN_LIMIT = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_GRAV_MAG  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_GYRO_LIM  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_ACCEL_LIM = 3'd4;

   typedef enum logic [2:0] {
      STAT_COLLECT = 3'd0,
      STAT_FEW     = 3'd1,
      STAT_GYRO    = 3'd2,
      STAT_ACCEL   = 3'd3,
      STAT_DONE    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SUM, S_MEAN_GO, S_MEAN_WAIT, S_VAR, S_VDIV_GO, S_VDIV_WAIT,
      S_NOISE, S_MSQ, S_SQRT, S_GMUL, S_GDIV_GO, S_GDIV_WAIT, S_LATCH, S_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [47:0]            ts;
      logic [LANES-1:0][31:0] samp;
   } item_type;

   typedef struct packed {
      logic [25:0] settle_time_us;
      logic [7:0]  window_limit;
      logic [30:0] gravity_magnitude;
      logic [30:0] gyro_var_limit;
      logic [30:0] accel_var_limit;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ design/sibg_front.sv @@
// ----------------------------------------------------------------------------
// sibg_front: input side of the static IMU initializer
// Accepts sample transactions and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sibg_front import sibg_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire item_type req_item,
   output logic          q_vld,
   output item_type      q_item,
   input  wire logic     q_pop
);

   item_type              buf_ff [QUE_DEPTH];
   logic [QUE_AW-1:0]     wr_ff;
   logic [QUE_AW-1:0]     rd_ff;
   logic [QUE_AW:0]       cnt_ff;
   logic                  push;

   assign req_stall = (cnt_ff == (QUE_AW+1)'(QUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_vld     = (cnt_ff != '0);
   assign q_item    = buf_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         // advance the count by push minus pop
         if (push && !q_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (!push && q_pop) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/sibg_div.sv @@
// ----------------------------------------------------------------------------
// sibg_div: shared serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sibg_div import sibg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic [DIV_NW-1:0] quo_ff;
   logic [DIV_DW-1:0] rem_ff;
   logic [DIV_DW-1:0] dvs_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DIV_DW:0]   sh;
   logic [DIV_DW:0]   diff;
   logic              ge;

   assign sh   = {rem_ff, quo_ff[DIV_NW-1]};
   assign diff = sh - {1'b0, dvs_ff};
   assign ge   = (sh >= {1'b0, dvs_ff});

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[DIV_NW-2:0], ge};
         rem_ff <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
      end
   end

endmodule

`default_nettype wire

@@ design/sibg_back.sv @@
// ----------------------------------------------------------------------------
// sibg_back: window store and attempt sequencer
// Writes samples into the ring window, walks it for means and variances,
// checks noise, finds the mean accel norm, derives gravity and latches results.
// ----------------------------------------------------------------------------
`default_nettype none

module sibg_back import sibg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_vld,
   input  wire item_type    q_item,
   output logic             q_pop,
   output div_req_type      div_req,
   input  wire div_rsp_type div_rsp,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output status_type       rsp_status,
   output logic [LAT_N-1:0][31:0] rsp_lat
);

   seq_state_type     state_ff, state_in;
   logic [WIN_AW-1:0] head_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [47:0]       start_ff;
   logic              done_ff;
   logic [FILL_W-1:0] cnt_ff;
   logic [2:0]        lane_ff;
   logic              grp_ff;
   logic              v1_ff, v2_ff, v3_ff;
   status_type        st_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [LAT_N-1:0][31:0] lat_ff;

   logic [31:0]       rd_ff   [LANES];
   logic [SUM_W-1:0]  sum_ff  [LANES];
   logic [31:0]       mean_ff [LANES];
   logic [ACC_W-1:0]  acc_ff  [LANES];
   logic [ACC_W-1:0]  var_ff  [LANES];
   logic [31:0]       ad_ff   [LANES];
   logic [63:0]       pr_ff   [LANES];
   logic [31:0]       grav_ff [3];
   logic [63:0]       pm_ff;
   logic [63:0]       sq_ff;
   logic [63:0]       sv_ff;
   logic [63:0]       res_ff;
   logic [63:0]       bit_ff;

   // pop-time decisions
   logic [47:0]       start_eff;
   logic              win_full;
   logic [WIN_AW-1:0] slot;
   logic [FILL_W-1:0] fill_ins;
   logic [WIN_AW-1:0] head_ins;
   logic [47:0]       elapsed;
   logic              go_attempt;
   logic              enough;

   logic              issue;
   logic              pass_end;
   logic [WIN_AW-1:0] rd_addr;
   logic [NUM_W-1:0]  num;
   logic              num_neg;
   logic [NUM_W-1:0]  mean_mag;
   logic [2:0]        nb;
   logic [30:0]       lim;
   logic              over;
   logic [2:0]        macc_idx;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       sq_t;
   logic              norm_zero;
   logic [FILL_W-1:0] trim_n;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_lat    = lat_ff;

   // --- pop-time window bookkeeping ---
   always_comb begin
      start_eff  = (fill_ff == '0) ? q_item.ts : start_ff;
      win_full   = (fill_ff == FILL_W'(WIN_DEPTH));
      slot       = win_full ? head_ff : head_ff + fill_ff[WIN_AW-1:0];
      fill_ins   = win_full ? fill_ff : fill_ff + 1'b1;
      head_ins   = win_full ? head_ff + 1'b1 : head_ff;
      elapsed    = q_item.ts - start_eff;
      go_attempt = (q_item.ts >= start_eff) && (elapsed > 48'(cfg.settle_time_us));
      enough     = (fill_ins >= FILL_W'(MIN_SAMPLES));
   end

   // --- datapath helpers ---
   always_comb begin
      rd_addr   = head_ff + cnt_ff[WIN_AW-1:0];
      pass_end  = (cnt_ff == fill_ff) && !v1_ff && !v2_ff && !v3_ff;
      num       = {sum_ff[lane_ff][SUM_W-1], sum_ff[lane_ff], 1'b0}
                  + NUM_W'(fill_ff);
      num_neg   = num[NUM_W-1];
      // floor division of a negative value through the unsigned divider
      mean_mag  = num_neg ? (~num + NUM_W'({fill_ff, 1'b0})) : num;
      nb        = grp_ff ? 3'd3 : 3'd0;
      lim       = grp_ff ? cfg.accel_var_limit : cfg.gyro_var_limit;
      over      = (var_ff[nb] > ACC_W'(lim)) || (var_ff[nb + 3'd1] > ACC_W'(lim))
                  || (var_ff[nb + 3'd2] > ACC_W'(lim));
      sq_t      = res_ff + bit_ff;
      norm_zero = (res_ff[31:0] == '0);
      trim_n    = fill_ff - FILL_W'(cfg.window_limit);
      macc_idx  = 3'd3;
   end

   // --- shared multiplier operand select ---
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_NOISE) begin
         if (cnt_ff[1:0] == 2'd3) begin
            mul_a = {1'b0, lim};
            mul_b = {1'b0, lim};
         end else begin
            mul_a = var_ff[nb + {1'b0, cnt_ff[1:0]}][31:0];
            mul_b = mul_a;
         end
      end else if (state_ff == S_MSQ) begin
         if (cnt_ff[1:0] != 2'd3) begin
            mul_a = mean_ff[macc_idx + {1'b0, cnt_ff[1:0]}];
            mul_a = mul_a[31] ? -mul_a : mul_a;
            mul_b = mul_a;
         end
      end else if (state_ff == S_GMUL) begin
         mul_a = mean_ff[macc_idx + lane_ff];
         mul_a = mul_a[31] ? -mul_a : mul_a;
         mul_b = {1'b0, cfg.gravity_magnitude};
      end
   end

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               state_in = (!done_ff && go_attempt && enough) ? S_SUM : S_FINISH;
            end
         end
         S_SUM:       if (pass_end) state_in = S_MEAN_GO;
         S_MEAN_GO:   state_in = S_MEAN_WAIT;
         S_MEAN_WAIT: begin
            if (div_rsp.done) state_in = (lane_ff == 3'd5) ? S_VAR : S_MEAN_GO;
         end
         S_VAR:       if (pass_end) state_in = S_VDIV_GO;
         S_VDIV_GO:   state_in = S_VDIV_WAIT;
         S_VDIV_WAIT: begin
            if (div_rsp.done) state_in = (lane_ff == 3'd5) ? S_NOISE : S_VDIV_GO;
         end
         S_NOISE: begin
            if (cnt_ff == FILL_W'(0) && over) begin
               state_in = S_FINISH;
            end else if (cnt_ff == FILL_W'(4)) begin
               if (sq_ff > pm_ff) state_in = S_FINISH;
               else if (grp_ff)   state_in = S_MSQ;
            end
         end
         S_MSQ:       if (cnt_ff == FILL_W'(3)) state_in = S_SQRT;
         S_SQRT:      if (bit_ff == 64'd1) state_in = S_GMUL;
         S_GMUL:      state_in = S_GDIV_GO;
         S_GDIV_GO: begin
            if (norm_zero) state_in = (lane_ff == 3'd2) ? S_LATCH : S_GMUL;
            else           state_in = S_GDIV_WAIT;
         end
         S_GDIV_WAIT: begin
            if (div_rsp.done) state_in = (lane_ff == 3'd2) ? S_LATCH : S_GMUL;
         end
         S_LATCH:     state_in = S_FINISH;
         S_FINISH:    state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // --- state outputs ---
   always_comb begin
      q_pop            = 1'b0;
      issue            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      unique case (state_ff)
         S_IDLE:  q_pop = q_vld && !rsp_valid_ff;
         S_SUM,
         S_VAR:   issue = (cnt_ff < fill_ff);
         S_MEAN_GO, S_MEAN_WAIT: begin
            div_req.start    = (state_ff == S_MEAN_GO);
            div_req.dividend = DIV_NW'(mean_mag);
            div_req.divisor  = DIV_DW'({fill_ff, 1'b0});
         end
         S_VDIV_GO, S_VDIV_WAIT: begin
            div_req.start    = (state_ff == S_VDIV_GO);
            div_req.dividend = DIV_NW'(acc_ff[lane_ff]);
            div_req.divisor  = DIV_DW'(fill_ff - 1'b1);
         end
         S_GDIV_GO, S_GDIV_WAIT: begin
            div_req.start    = (state_ff == S_GDIV_GO) && !norm_zero;
            div_req.dividend = pm_ff;
            div_req.divisor  = res_ff[31:0];
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // --- sample window memories ---
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [31:0] mem [WIN_DEPTH];

      always_ff @(posedge clock) begin
         if (q_pop && !done_ff) begin
            mem[slot] <= q_item.samp[k];
         end
      end

      always_ff @(posedge clock) begin
         rd_ff[k] <= mem[rd_addr];
      end
   end

   // --- control registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         fill_ff       <= '0;
         start_ff      <= '0;
         done_ff       <= 1'b0;
         cnt_ff        <= '0;
         lane_ff       <= '0;
         grp_ff        <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         st_ff         <= STAT_COLLECT;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STAT_COLLECT;
         lat_ff        <= '0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         if (issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  cnt_ff <= '0;
                  if (done_ff) begin
                     st_ff <= STAT_DONE;
                  end else begin
                     start_ff <= start_eff;
                     fill_ff  <= fill_ins;
                     head_ff  <= head_ins;
                     st_ff    <= go_attempt ? STAT_FEW : STAT_COLLECT;
                  end
               end
            end
            S_SUM: begin
               if (pass_end) lane_ff <= '0;
            end
            S_MEAN_WAIT: begin
               if (div_rsp.done) begin
                  if (lane_ff == 3'd5) begin
                     lane_ff <= '0;
                     cnt_ff  <= '0;
                  end else begin
                     lane_ff <= lane_ff + 1'b1;
                  end
               end
            end
            S_VDIV_WAIT: begin
               if (div_rsp.done) begin
                  lane_ff <= lane_ff + 1'b1;
                  if (lane_ff == 3'd5) begin
                     cnt_ff <= '0;
                     grp_ff <= 1'b0;
                  end
               end
            end
            S_NOISE: begin
               if (cnt_ff == FILL_W'(4)) begin
                  cnt_ff <= '0;
                  if (sq_ff > pm_ff) st_ff <= grp_ff ? STAT_ACCEL : STAT_GYRO;
                  else               grp_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == FILL_W'(0) && over) begin
                     st_ff <= grp_ff ? STAT_ACCEL : STAT_GYRO;
                  end
               end
            end
            S_MSQ: begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            S_SQRT: begin
               lane_ff <= '0;
            end
            S_GDIV_GO: begin
               if (norm_zero) lane_ff <= lane_ff + 1'b1;
            end
            S_GDIV_WAIT: begin
               if (div_rsp.done) lane_ff <= lane_ff + 1'b1;
            end
            S_LATCH: begin
               for (int j = 0; j < 3; j++) begin
                  logic [32:0] s;
                  s = {mean_ff[3+j][31], mean_ff[3+j]} + {grav_ff[j][31], grav_ff[j]};
                  lat_ff[j]   <= mean_ff[j];
                  lat_ff[6+j] <= grav_ff[j];
                  if (s[32] != s[31]) begin
                     lat_ff[3+j] <= s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  end else begin
                     lat_ff[3+j] <= s[31:0];
                  end
               end
               done_ff <= 1'b1;
               st_ff   <= STAT_DONE;
            end
            S_FINISH: begin
               // drop the oldest entries beyond the window limit
               if (!done_ff && (fill_ff > FILL_W'(cfg.window_limit))) begin
                  head_ff <= head_ff + trim_n[WIN_AW-1:0];
                  fill_ff <= FILL_W'(cfg.window_limit);
               end
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= st_ff;
            end
            default: begin
               lane_ff <= lane_ff;
            end
         endcase
      end
   end

   // --- arithmetic payload registers ---
   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         logic [32:0] dd;
         dd        = {rd_ff[k][31], rd_ff[k]} - {mean_ff[k][31], mean_ff[k]};
         ad_ff[k] <= dd[32] ? 32'(-dd) : dd[31:0];
         pr_ff[k] <= ad_ff[k] * ad_ff[k];
      end
      if (q_pop) begin
         for (int k = 0; k < LANES; k++) begin
            sum_ff[k] <= '0;
            acc_ff[k] <= '0;
         end
      end
      if (state_ff == S_SUM && v1_ff) begin
         for (int k = 0; k < LANES; k++) begin
            sum_ff[k] <= sum_ff[k] + {{(SUM_W-32){rd_ff[k][31]}}, rd_ff[k]};
         end
      end
      if (state_ff == S_VAR && v3_ff) begin
         for (int k = 0; k < LANES; k++) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(pr_ff[k][63:16]);
         end
      end
      if (state_ff == S_MEAN_WAIT && div_rsp.done) begin
         mean_ff[lane_ff] <= num_neg ? -div_rsp.quot[31:0] : div_rsp.quot[31:0];
      end
      if (state_ff == S_VDIV_WAIT && div_rsp.done) begin
         var_ff[lane_ff] <= div_rsp.quot[ACC_W-1:0];
      end
      if (state_ff == S_NOISE || state_ff == S_MSQ || state_ff == S_GMUL) begin
         pm_ff <= mul_a * mul_b;
      end
      if (state_ff == S_NOISE || state_ff == S_MSQ) begin
         if (cnt_ff == FILL_W'(0)) sq_ff <= '0;
         else                      sq_ff <= sq_ff + pm_ff;
      end
      if (state_ff == S_MSQ && cnt_ff == FILL_W'(3)) begin
         sv_ff  <= sq_ff + pm_ff;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end
      if (state_ff == S_SQRT) begin
         if (sv_ff >= sq_t) begin
            sv_ff  <= sv_ff - sq_t;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (state_ff == S_GDIV_GO && norm_zero) begin
         grav_ff[lane_ff[1:0]] <= '0;
      end
      if (state_ff == S_GDIV_WAIT && div_rsp.done) begin
         logic [31:0] m;
         m = mean_ff[macc_idx + lane_ff];
         grav_ff[lane_ff[1:0]] <= (!m[31] && m != '0) ? -div_rsp.quot[31:0]
                                                      : div_rsp.quot[31:0];
      end
   end

`ifndef SYNTHESIS
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("done flag cleared after success");
   a_finish_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> rsp_valid_ff)
      else $error("finish did not load a response");
   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != S_IDLE))
      else $error("popped item not processed");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (fill_ff <= FILL_W'(WIN_DEPTH)))
      else $error("window fill beyond depth");
`endif

endmodule

`default_nettype wire

@@ design/static_imu_bias_gravity_init.sv @@
// ----------------------------------------------------------------------------
// static_imu_bias_gravity_init: static IMU bias and gravity initializer
// Top level: configuration registers, input queue, window sequencer, divider.
// ----------------------------------------------------------------------------
// Each req_ transaction is one time-stamped gyro/accel sample in Q16.16 and
// yields exactly one rsp_ transaction with a status and the latched gyro bias,
// accel bias and gravity (zero until initialization succeeds). A full
// attempt over n window samples makes two walks of the window memories,
// then up to fifteen divisions on the shared one bit per cycle divider,
// plus a 32-step square root. A queue of two samples takes new
// transactions while an attempt runs or a response waits. After success
// every sample answers initialized without starting another attempt.
// The window stores need no clearing pass after reset.
`default_nettype none

module static_imu_bias_gravity_init import sibg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [47:0]       req_timestamp_us,
   input  wire logic signed [31:0] req_gyro_x,
   input  wire logic signed [31:0] req_gyro_y,
   input  wire logic signed [31:0] req_gyro_z,
   input  wire logic signed [31:0] req_accel_x,
   input  wire logic signed [31:0] req_accel_y,
   input  wire logic signed [31:0] req_accel_z,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic signed [31:0]     rsp_gyro_bias_x,
   output logic signed [31:0]     rsp_gyro_bias_y,
   output logic signed [31:0]     rsp_gyro_bias_z,
   output logic signed [31:0]     rsp_accel_bias_x,
   output logic signed [31:0]     rsp_accel_bias_y,
   output logic signed [31:0]     rsp_accel_bias_z,
   output logic signed [31:0]     rsp_gravity_x,
   output logic signed [31:0]     rsp_gravity_y,
   output logic signed [31:0]     rsp_gravity_z,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   cfg_type                cfg_ff;
   item_type               req_item;
   item_type               q_item;
   logic                   q_vld;
   logic                   q_pop;
   div_req_type            div_req;
   div_rsp_type            div_rsp;
   status_type             status;
   logic [LAT_N-1:0][31:0] lat;

   // Configuration writes land directly; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_time_us    <= 26'd10000000;
         cfg_ff.window_limit      <= 8'd255;
         cfg_ff.gravity_magnitude <= 31'd642908;
         cfg_ff.gyro_var_limit    <= 31'd32768;
         cfg_ff.accel_var_limit   <= 31'd3277;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SETTLE:    cfg_ff.settle_time_us    <= csr_wdata[25:0];
            CSR_WIN_LIMIT: cfg_ff.window_limit      <= csr_wdata[7:0];
            CSR_GRAV_MAG:  cfg_ff.gravity_magnitude <= csr_wdata;
            CSR_GYRO_LIM:  cfg_ff.gyro_var_limit    <= csr_wdata;
            CSR_ACCEL_LIM: cfg_ff.accel_var_limit   <= csr_wdata;
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Pack the sample; lane order gyro x/y/z then accel x/y/z.
   assign req_item.ts      = req_timestamp_us;
   assign req_item.samp[0] = req_gyro_x;
   assign req_item.samp[1] = req_gyro_y;
   assign req_item.samp[2] = req_gyro_z;
   assign req_item.samp[3] = req_accel_x;
   assign req_item.samp[4] = req_accel_y;
   assign req_item.samp[5] = req_accel_z;

   sibg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_vld     (q_vld),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   sibg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_vld      (q_vld),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (status),
      .rsp_lat    (lat)
   );

   sibg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Latched results change only while no response is pending, so they
   // drive the response fields directly and hold under stall.
   assign rsp_status       = status;
   assign rsp_gyro_bias_x  = lat[0];
   assign rsp_gyro_bias_y  = lat[1];
   assign rsp_gyro_bias_z  = lat[2];
   assign rsp_accel_bias_x = lat[3];
   assign rsp_accel_bias_y = lat[4];
   assign rsp_accel_bias_z = lat[5];
   assign rsp_gravity_x    = lat[6];
   assign rsp_gravity_y    = lat[7];
   assign rsp_gravity_z    = lat[8];

endmodule

`default_nettype wire

@@ test/static_imu_bias_gravity_init_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_imu_bias_gravity_init_test: self-checking bench of the initializer
// Streams time-stamped gyro/accel samples through the block under bursty
// sending and patterned stalls, predicts status and latched results for each
// accepted sample and compares every response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module static_imu_bias_gravity_init_test;
   import sibg_pkg::*;

   typedef struct packed {
      logic [47:0]      ts;
      logic [2:0][31:0] gyro;
      logic [2:0][31:0] accel;
   } sample_type;

   typedef struct packed {
      status_type       status;
      logic [8:0][31:0] lat;
   } answer_type;

   // indexes past the register list; writes there must be ignored
   localparam logic [CSR_IW-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
   localparam int TBQ_DEPTH = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [47:0] req_timestamp_us = '0;
   logic signed [31:0] req_gyro_x = '0, req_gyro_y = '0, req_gyro_z = '0;
   logic signed [31:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic signed [31:0] rsp_gyro_bias_x, rsp_gyro_bias_y, rsp_gyro_bias_z;
   logic signed [31:0] rsp_accel_bias_x, rsp_accel_bias_y, rsp_accel_bias_z;
   logic signed [31:0] rsp_gravity_x, rsp_gravity_y, rsp_gravity_z;
   logic csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   static_imu_bias_gravity_init uut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the block: window, start time, lock and configuration
   // ---------------------------------------------------------------------
   logic signed [31:0] win_mem [LANES][WIN_DEPTH];
   int unsigned        win_head, win_fill;
   logic [47:0]        start_us;
   bit                 locked;
   logic [8:0][31:0]   held;
   logic [25:0]        cfg_settle = 26'd10000000;
   logic [7:0]         cfg_wlim = 8'd255;
   logic [30:0]        cfg_gmag = 31'd642908;
   logic [30:0]        cfg_glim = 31'd32768;
   logic [30:0]        cfg_alim = 31'd3277;

   // pending samples and expected answers, each a ring with head and count
   sample_type  pend_buf [TBQ_DEPTH];
   int          pend_head = 0;
   int          pend_count = 0;
   answer_type  due_buf [TBQ_DEPTH];
   int          due_head = 0;
   int          due_count = 0;
   int          err_count = 0;
   bit          req_sent = 0;
   bit          hold_request = 0;
   logic [47:0] now_us = '0;

   function automatic bit var_too_high(longint unsigned v0, longint unsigned v1,
                                       longint unsigned v2, logic [30:0] lim);
      longint unsigned l;
      l = {33'd0, lim};
      if (v0 > l || v1 > l || v2 > l) return 1;
      return (v0 * v0 + v1 * v1 + v2 * v2) > l * l;
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Run one initialization attempt over the current window.
   function automatic status_type attempt_init();
      longint          sum, num, den, d, q;
      longint          mn[LANES];
      longint          gv[3];
      longint unsigned acc, a, msq, root, t, g;
      longint unsigned vr[LANES];
      int unsigned     n;
      n = win_fill;
      if (n < MIN_SAMPLES || n < 2) return STAT_FEW;
      for (int k = 0; k < LANES; k++) begin
         sum = 0;
         for (int unsigned i = 0; i < n; i++)
            sum += win_mem[k][(win_head + i) % WIN_DEPTH];
         num = 2 * sum + n;
         den = 2 * longint'(n);
         q = num / den;
         if (num % den != 0 && num < 0) q--;
         mn[k] = q;
         acc = 0;
         for (int unsigned i = 0; i < n; i++) begin
            d = win_mem[k][(win_head + i) % WIN_DEPTH] - mn[k];
            a = (d < 0) ? -d : d;
            acc += (a * a) >> 16;
         end
         vr[k] = acc / (n - 1);
      end
      if (var_too_high(vr[0], vr[1], vr[2], cfg_glim)) return STAT_GYRO;
      if (var_too_high(vr[3], vr[4], vr[5], cfg_alim)) return STAT_ACCEL;
      msq = 0;
      for (int k = 0; k < 3; k++) begin
         a = (mn[3+k] < 0) ? -mn[3+k] : mn[3+k];
         msq += a * a;
      end
      // bitwise floor square root of the squared mean accel length
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         t = root | (64'd1 << b);
         if (t * t <= msq) root = t;
      end
      for (int k = 0; k < 3; k++) begin
         a = (mn[3+k] < 0) ? -mn[3+k] : mn[3+k];
         g = (root != 0) ? (a * {33'd0, cfg_gmag}) / root : 0;
         gv[k] = (mn[3+k] > 0) ? -longint'(g) : longint'(g);
      end
      for (int k = 0; k < 3; k++) begin
         held[k]   = mn[k][31:0];
         held[3+k] = clip32(mn[3+k] + gv[k]);
         held[6+k] = clip32(gv[k]);
      end
      locked = 1;
      return STAT_DONE;
   endfunction

   // Advance the shadow state by one sample and return the expected answer.
   function automatic answer_type predict_init(sample_type s);
      answer_type  r;
      int unsigned slot;
      r.status = STAT_COLLECT;
      if (locked) begin
         r.status = STAT_DONE;
      end else begin
         if (win_fill == 0) start_us = s.ts;
         if (win_fill < WIN_DEPTH) begin
            slot = (win_head + win_fill) % WIN_DEPTH;
            win_fill++;
         end else begin
            slot = win_head;
            win_head = (win_head + 1) % WIN_DEPTH;
         end
         // packed triples hold x in the top word, so lane k takes word 2-k
         for (int k = 0; k < 3; k++) begin
            win_mem[k][slot]   = s.gyro[2-k];
            win_mem[3+k][slot] = s.accel[2-k];
         end
         if (s.ts >= start_us && s.ts - start_us > {22'd0, cfg_settle})
            r.status = attempt_init();
         if (!locked)
            while (win_fill > cfg_wlim) begin
               win_head = (win_head + 1) % WIN_DEPTH;
               win_fill--;
            end
      end
      r.lat = held;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: bursts of random length separated by random gaps
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin
      sample_type s;
      if (!reset && (!req_valid || req_sent)) begin
         req_sent = 0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pend_count > 0) begin
            s = pend_buf[pend_head];
            pend_head = (pend_head + 1) % TBQ_DEPTH;
            pend_count--;
            req_timestamp_us <= s.ts;
            {req_gyro_x, req_gyro_y, req_gyro_z} <= s.gyro;
            {req_accel_x, req_accel_y, req_accel_z} <= s.accel;
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               // new burst; a quarter of them follow without any gap
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall mode changes at random intervals; a long hold-off
   // on request lets the input queue fill and stall the sender
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 120);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = 4000;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted sample, check each accepted answer
   // ---------------------------------------------------------------------
   string lat_names[9] = '{"gyro_bias_x", "gyro_bias_y", "gyro_bias_z",
                           "accel_bias_x", "accel_bias_y", "accel_bias_z",
                           "gravity_x", "gravity_y", "gravity_z"};

   always @(posedge clock) begin
      sample_type s;
      answer_type want;
      logic [8:0][31:0] got;
      if (!reset && req_valid && !req_stall) begin
         s.ts = req_timestamp_us;
         s.gyro = {req_gyro_x, req_gyro_y, req_gyro_z};
         s.accel = {req_accel_x, req_accel_y, req_accel_z};
         due_buf[(due_head + due_count) % TBQ_DEPTH] = predict_init(s);
         due_count++;
         req_sent = 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_gravity_z, rsp_gravity_y, rsp_gravity_x,
                rsp_accel_bias_z, rsp_accel_bias_y, rsp_accel_bias_x,
                rsp_gyro_bias_z, rsp_gyro_bias_y, rsp_gyro_bias_x};
         if (due_count == 0) begin
            $display("%0t: unexpected response, status %0d", $time, rsp_status);
            err_count++;
         end else begin
            want = due_buf[due_head];
            due_head = (due_head + 1) % TBQ_DEPTH;
            due_count--;
            if (want.status !== rsp_status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               err_count++;
            end
            for (int k = 0; k < 9; k++)
               if (want.lat[k] !== got[k]) begin
                  $display("%0t: %s expected %h actual %h",
                           $time, lat_names[k], want.lat[k], got[k]);
                  err_count++;
               end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_sample(logic [47:0] ts, logic [2:0][31:0] g,
                              logic [2:0][31:0] a);
      sample_type s;
      s.ts = ts;
      s.gyro = g;
      s.accel = a;
      pend_buf[(pend_head + pend_count) % TBQ_DEPTH] = s;
      pend_count++;
   endtask

   // Hold until every sample is sent and every answer is back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pend_count != 0 || req_valid || due_count != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SETTLE:    cfg_settle = val[25:0];
         CSR_WIN_LIMIT: cfg_wlim = val[7:0];
         CSR_GRAV_MAG:  cfg_gmag = val;
         CSR_GYRO_LIM:  cfg_glim = val;
         CSR_ACCEL_LIM: cfg_alim = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] jitter(logic [31:0] base, int unsigned amp);
      return base + $urandom_range(0, 2 * amp) - amp;
   endfunction

   function automatic logic [30:0] pick_limit();
      case ($urandom_range(0, 3))
         0: return 31'd0;
         1: return MAX31;
         default: return 31'($urandom_range(0, 32'h7FFF_FFFF));
      endcase
   endfunction

   // Mostly a standing sensor with random bias and noise; a tenth are
   // full-range samples at random stamps.
   task automatic stand_still(int count, int unsigned g_amp, int unsigned a_amp);
      logic [2:0][31:0] gb, ab, g, a;
      for (int k = 0; k < 3; k++) begin
         gb[k] = $urandom_range(0, 1) ? $urandom : jitter(32'd0, 4000);
         ab[k] = jitter(32'd0, 700000);
      end
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < 3; k++) begin
               g[k] = $urandom;
               a[k] = $urandom;
            end
            push_sample(48'({$urandom, $urandom}), g, a);
         end else begin
            for (int k = 0; k < 3; k++) begin
               g[k] = jitter(gb[k], g_amp);
               a[k] = jitter(ab[k], a_amp);
            end
            now_us += $urandom_range(1, 5000);
            push_sample(now_us, g, a);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   logic [2:0][31:0] zero3 = '0;
   logic [2:0][31:0] max3 = {3{32'h7FFF_FFFF}};
   logic [2:0][31:0] min3 = {3{32'h8000_0000}};
   logic [2:0][31:0] ones3 = {3{32'hFFFF_FFFF}};

   initial begin
      logic [2:0][31:0] g, a;
      int unsigned fail_side;
      win_head = 0;
      win_fill = 0;
      start_us = '0;
      locked = 0;
      held = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, start time, exact and exceeded settle time
      push_sample(48'd0, zero3, zero3);
      push_sample(48'd5, max3, min3);
      push_sample(48'd10000000, min3, max3);
      push_sample(48'd10000001, ones3, zero3);
      wait_drained();

      // masked settle value, ignored indexes, empty-window trimming
      write_reg(CSR_SETTLE, {CSR_DW{1'b1}});
      write_reg(CSR_SPARE_LO, 31'd0);
      write_reg(CSR_SPARE_HI, {CSR_DW{1'b1}});
      write_reg(CSR_WIN_LIMIT, 31'd0);
      push_sample(48'hFFFF_FFFF_FFFF, ones3, ones3);
      push_sample(48'd100, max3, max3);
      push_sample(48'd200, min3, min3);
      wait_drained();

      // time going backwards, then too few, then gyro noise (still in the window under the noisy accel samples)
      write_reg(CSR_SETTLE, 31'd0);
      write_reg(CSR_WIN_LIMIT, 31'd10);
      push_sample(48'd1000, zero3, zero3);
      push_sample(48'd500, max3, zero3);
      for (int i = 0; i < 9; i++)
         push_sample(48'd1001 + i, (i % 2) ? max3 : min3, zero3);
      for (int i = 0; i < 4; i++)
         push_sample(48'd2000 + i, zero3, (i % 2) ? max3 : ones3);
      wait_drained();

      // random phases; each picks a failing side so the block stays open
      now_us = 48'd3000;
      for (int p = 0; p < 9; p++) begin
         case ($urandom_range(0, 3))
            0: write_reg(CSR_SETTLE, 31'd0);
            1: write_reg(CSR_SETTLE, 31'($urandom_range(0, 20000)));
            2: write_reg(CSR_SETTLE, 31'd60000000);
            default: write_reg(CSR_SETTLE, 31'h3FF_FFFF);
         endcase
         case ($urandom_range(0, 5))
            0: write_reg(CSR_WIN_LIMIT, 31'($urandom_range(0, 9)));
            default: write_reg(CSR_WIN_LIMIT, 31'($urandom_range(10, 40)));
         endcase
         write_reg(CSR_GRAV_MAG, pick_limit());
         fail_side = $urandom_range(0, 1);
         write_reg(CSR_GYRO_LIM, fail_side ? 31'd0 : MAX31);
         write_reg(CSR_ACCEL_LIM, fail_side ? pick_limit() : 31'd0);
         stand_still($urandom_range(25, 40), 50000, 50000);
         wait_drained();
      end

      // empty the window, then fill it to its largest size with the
      // receiver held off for a long stretch
      write_reg(CSR_WIN_LIMIT, 31'd0);
      now_us += 1;
      push_sample(now_us, zero3, zero3);
      wait_drained();
      write_reg(CSR_SETTLE, 31'd60000000);
      write_reg(CSR_WIN_LIMIT, 31'd255);
      write_reg(CSR_GYRO_LIM, 31'd0);
      hold_request = 1;
      for (int i = 0; i < 255; i++) begin
         for (int k = 0; k < 3; k++) begin
            g[k] = jitter(32'd100, 8000);
            a[k] = jitter(32'hFFF6_0000, 8000);
         end
         now_us += $urandom_range(1, 3000);
         push_sample(now_us, g, a);
      end
      now_us += 48'd61000000;
      for (int i = 0; i < 4; i++) begin
         now_us += 1;
         push_sample(now_us, max3, min3);
      end
      wait_drained();

      // final phase: quiet sensor, generous limits, initialization succeeds
      write_reg(CSR_SETTLE, 31'd0);
      write_reg(CSR_WIN_LIMIT, 31'd20);
      write_reg(CSR_GRAV_MAG, 31'd642908);
      write_reg(CSR_GYRO_LIM, MAX31);
      write_reg(CSR_ACCEL_LIM, MAX31);
      for (int i = 0; i < 24; i++) begin
         g = {jitter(32'd300, 200), jitter(-32'sd50, 200), jitter(32'd0, 200)};
         a = {jitter(32'd0, 300), jitter(32'd20000, 300), jitter(-32'sd640000, 300)};
         now_us += $urandom_range(1, 5000);
         push_sample(now_us, g, a);
      end
      wait_drained();

      repeat (50) @(posedge clock);
      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #60_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
design/sibg_pkg.sv
design/sibg_front.sv
design/sibg_div.sv
design/sibg_back.sv
design/static_imu_bias_gravity_init.sv
test/static_imu_bias_gravity_init_test.sv
